// ----- rtl/core/icl_pkg.sv -----
// icl_pkg: shared types and constants of the inode cache with lru replacement
// depends on nothing; used by the channel interfaces and the inode_cache_lru top level

package icl_pkg;

   localparam int DEFAULT_SLOTS = 16;
   localparam int KEY_W         = 16;
   localparam int STAMP_W       = 32;
   localparam int COUNT_W       = 17;
   localparam int OP_W          = 2;
   localparam int STATUS_W      = 2;
   localparam int SLOT_W        = 4;

   localparam logic [COUNT_W-1:0] INODE_COUNT_RESET = 17'h10000;

   typedef enum logic [OP_W-1:0] {
      OP_LOOKUP = 2'd0,
      OP_PUT    = 2'd1,
      OP_REMOVE = 2'd2
   } op_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK     = 2'd0,
      ST_RANGE  = 2'd1,
      ST_ABSENT = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_DONE
   } state_type;

   // one entry of the slot memory
   typedef struct packed {
      logic [KEY_W-1:0]   key;
      logic [STAMP_W-1:0] stamp;
   } entry_type;

endpackage

// ----- rtl/core/icl_req_if.sv -----
// icl_req_if: request channel (op and key) with valid/ready handshake
// depends on icl_pkg for field widths

interface icl_req_if;
   import icl_pkg::*;

   logic               valid;
   logic               ready;
   logic [OP_W-1:0]    op;
   logic [KEY_W-1:0]   key;

   modport source (output valid, output op, output key, input ready);
   modport sink   (input valid, input op, input key, output ready);
endinterface

// ----- rtl/core/icl_rsp_if.sv -----
// icl_rsp_if: response channel of the inode cache with valid/ready handshake
// depends on icl_pkg for field widths

interface icl_rsp_if;
   import icl_pkg::*;

   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic                hit;
   logic [SLOT_W-1:0]   slot;
   logic                evicted;
   logic [KEY_W-1:0]    evicted_key;

   modport source (output valid, output status, output hit, output slot,
                   output evicted, output evicted_key, input ready);
   modport sink   (input valid, input status, input hit, input slot,
                   input evicted, input evicted_key, output ready);
endinterface

// ----- rtl/core/inode_cache_lru.sv -----
// inode_cache_lru: fully associative inode number cache, timestamp lru replacement
// depends on icl_pkg, icl_req_if and icl_rsp_if
//
// flow: the request word is registered, then the slot memory is scanned, one entry read per cycle
//   through its single read port; in the done state a put is written back and the response
//   word loaded into the output register; a new request is taken only once back in idle
// a new request is taken while the previous response still waits in the output register
// reset: synchronous; clears valid bits, stamp counter and inode_count (to 65536),
//   no clearing pass over the slot memory

module inode_cache_lru #(
   parameter int SLOTS = icl_pkg::DEFAULT_SLOTS
) (
   input  logic                       clock,
   input  logic                       reset,
   icl_req_if.sink                    req_bus,
   icl_rsp_if.source                  rsp_bus,
   input  logic                       csr_wr_en,
   input  logic [icl_pkg::COUNT_W-1:0] csr_wr_data
);
   import icl_pkg::*;

   localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);

   // slot memory: key and stamp per slot
   entry_type            mem [SLOTS];
   entry_type            rd_word_ff;

   state_type            state_ff, state_in;
   logic [SLOTS-1:0]     valid_ff;
   logic [STAMP_W-1:0]   stamp_ff;
   logic [COUNT_W-1:0]   inode_count_ff;

   logic [OP_W-1:0]      op_ff;
   logic [KEY_W-1:0]     key_ff;

   logic [IW-1:0]        addr_ff;
   logic                 iss_ff;
   logic                 rd_vld_ff;
   logic [IW-1:0]        rd_idx_ff;

   logic                 found_ff, empty_ff;
   logic [IW-1:0]        match_idx_ff, empty_idx_ff, min_idx_ff;
   logic [STAMP_W-1:0]   min_stamp_ff;
   logic [KEY_W-1:0]     min_key_ff;

   logic                 rsp_valid_ff;
   logic [STATUS_W-1:0]  rsp_status_ff;
   logic                 rsp_hit_ff;
   logic [SLOT_W-1:0]    rsp_slot_ff;
   logic                 rsp_evicted_ff;
   logic [KEY_W-1:0]     rsp_evicted_key_ff;

   logic                 req_take;
   logic                 out_free;
   logic                 finish;
   logic                 scan_last;
   logic                 fin_put, fin_remove;
   logic [IW-1:0]        put_idx;
   logic                 put_evicts;
   logic                 rd_slot_valid;

   logic [STATUS_W-1:0]  res_status;
   logic                 res_hit;
   logic [SLOT_W-1:0]    res_slot;
   logic                 res_evicted;
   logic [KEY_W-1:0]     res_evicted_key;

   assign req_bus.ready = (state_ff == S_IDLE);
   assign req_take      = req_bus.valid && (state_ff == S_IDLE);
   assign out_free      = !rsp_valid_ff || rsp_bus.ready;
   assign finish        = (state_ff == S_DONE) && out_free;
   assign scan_last     = rd_vld_ff && (rd_idx_ff == LAST_IDX);
   assign rd_slot_valid = valid_ff[rd_idx_ff];

   assign put_evicts = !found_ff && !empty_ff;
   assign put_idx    = found_ff ? match_idx_ff : (empty_ff ? empty_idx_ff : min_idx_ff);
   assign fin_put    = finish && (op_ff == OP_PUT);
   assign fin_remove = finish && (op_ff == OP_REMOVE) && found_ff;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_take) state_in = S_SCAN;
         end
         S_SCAN: begin
            if (scan_last) state_in = S_DONE;
         end
         S_DONE: begin
            if (out_free) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   // result word from the scan summary
   always_comb begin
      res_status      = ST_OK;
      res_hit         = 1'b0;
      res_slot        = '0;
      res_evicted     = 1'b0;
      res_evicted_key = '0;
      case (op_ff)
         OP_LOOKUP: begin
            if ({1'b0, key_ff} >= inode_count_ff) begin
               res_status = ST_RANGE;
            end else if (found_ff) begin
               res_hit  = 1'b1;
               res_slot = SLOT_W'(match_idx_ff);
            end else begin
               res_status = ST_ABSENT;
            end
         end
         OP_PUT: begin
            res_hit         = found_ff;
            res_slot        = SLOT_W'(put_idx);
            res_evicted     = put_evicts;
            res_evicted_key = put_evicts ? min_key_ff : '0;
         end
         OP_REMOVE: begin
            if (found_ff) begin
               res_hit  = 1'b1;
               res_slot = SLOT_W'(match_idx_ff);
            end else begin
               res_status = ST_ABSENT;
            end
         end
         default: ;
      endcase
   end

   // slot memory: one read and one write port
   always_ff @(posedge clock) begin
      rd_word_ff <= mem[addr_ff];
      if (fin_put) begin
         mem[put_idx] <= '{key: key_ff, stamp: stamp_ff};
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff       <= '0;
         stamp_ff       <= '0;
         inode_count_ff <= INODE_COUNT_RESET;
         iss_ff         <= 1'b0;
         rd_vld_ff      <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         if (csr_wr_en) inode_count_ff <= csr_wr_data;

         if (req_take) begin
            iss_ff <= 1'b1;
         end else if (iss_ff && (addr_ff == LAST_IDX)) begin
            iss_ff <= 1'b0;
         end
         rd_vld_ff <= iss_ff;

         if (fin_put) begin
            valid_ff[put_idx] <= 1'b1;
            stamp_ff          <= stamp_ff + 1'b1;
         end else if (fin_remove) begin
            valid_ff[match_idx_ff] <= 1'b0;
         end

         if (finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // request, scan address and scan summary
   always_ff @(posedge clock) begin
      if (req_take) begin
         op_ff    <= req_bus.op;
         key_ff   <= req_bus.key;
         addr_ff  <= '0;
         found_ff <= 1'b0;
         empty_ff <= 1'b0;
      end else begin
         if (iss_ff && (addr_ff != LAST_IDX)) addr_ff <= addr_ff + 1'b1;
         if (rd_vld_ff) begin
            if (!found_ff && rd_slot_valid && (rd_word_ff.key == key_ff)) begin
               found_ff     <= 1'b1;
               match_idx_ff <= rd_idx_ff;
            end
            if (!empty_ff && !rd_slot_valid) begin
               empty_ff     <= 1'b1;
               empty_idx_ff <= rd_idx_ff;
            end
            // strict compare keeps the first slot on equal stamps
            if ((rd_idx_ff == '0) || (rd_word_ff.stamp < min_stamp_ff)) begin
               min_stamp_ff <= rd_word_ff.stamp;
               min_idx_ff   <= rd_idx_ff;
               min_key_ff   <= rd_word_ff.key;
            end
         end
      end
      rd_idx_ff <= addr_ff;
   end

   // output register
   always_ff @(posedge clock) begin
      if (finish) begin
         rsp_status_ff      <= res_status;
         rsp_hit_ff         <= res_hit;
         rsp_slot_ff        <= res_slot;
         rsp_evicted_ff     <= res_evicted;
         rsp_evicted_key_ff <= res_evicted_key;
      end
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.status      = rsp_status_ff;
   assign rsp_bus.hit         = rsp_hit_ff;
   assign rsp_bus.slot        = rsp_slot_ff;
   assign rsp_bus.evicted     = rsp_evicted_ff;
   assign rsp_bus.evicted_key = rsp_evicted_key_ff;

`ifndef NO_ASSERTIONS
   // an eviction happens only when every slot holds an entry
   a_evict_full: assert property (@(posedge clock) disable iff (reset)
      (fin_put && put_evicts) |-> (&valid_ff))
      else $error("eviction with a free slot");

   // the slot written by a put is valid afterwards
   a_put_valid: assert property (@(posedge clock) disable iff (reset)
      fin_put |=> valid_ff[$past(put_idx)])
      else $error("put slot not valid");

   // the stamp counter moves only on a finished put
   a_stamp_step: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && (stamp_ff != $past(stamp_ff))) |-> $past(fin_put))
      else $error("stamp counter moved without a put");

   // a recorded match points at a valid slot
   a_match_valid: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_DONE) && found_ff) |-> valid_ff[match_idx_ff])
      else $error("match on an invalid slot");

   // a response word appears only out of the done state
   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && $rose(rsp_valid_ff)) |-> ($past(state_ff) == S_DONE))
      else $error("response without a finished scan");
`endif

endmodule

// ----- test/tb.sv -----
// tb: self-checking testbench for inode_cache_lru, the lru inode number cache
// depends on icl_pkg, icl_req_if, icl_rsp_if and the inode_cache_lru top level
// keeps its own copy of the slot table and checks every response word in order

module tb;
   import icl_pkg::*;

   localparam int SLOTS = DEFAULT_SLOTS;
   localparam logic [OP_W-1:0] OP_UNDEFINED = 2'd3;
   localparam logic [COUNT_W-1:0] COUNT_FULL = 17'h10000;

   typedef struct packed {
      status_type          status;
      logic                hit;
      logic [SLOT_W-1:0]   slot;
      logic                evicted;
      logic [KEY_W-1:0]    evicted_key;
   } answer_type;

   logic clock = 1'b0;
   logic reset;
   logic csr_wr_en;
   logic [COUNT_W-1:0] csr_wr_data;

   icl_req_if req_bus ();
   icl_rsp_if rsp_bus ();

   inode_cache_lru #(.SLOTS(SLOTS)) dut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // shadow of the slot table
   bit                 line_valid [SLOTS];
   logic [KEY_W-1:0]   line_key   [SLOTS];
   logic [STAMP_W-1:0] line_stamp [SLOTS];
   logic [STAMP_W-1:0] stamp_now;
   logic [COUNT_W-1:0] inode_limit;

   answer_type answers_due [$];
   int fault_count = 0;
   int send_idle_pct = 0;
   int stall_pct = 0;

   function automatic answer_type resolve_request(input logic [OP_W-1:0] op,
                                                  input logic [KEY_W-1:0] key);
      answer_type a;
      int found;
      int pick;
      int i;
      a = '0;
      found = -1;
      pick = -1;
      for (i = 0; i < SLOTS; i++) begin
         if (found < 0 && line_valid[i] && line_key[i] == key) found = i;
      end
      case (op)
         OP_LOOKUP: begin
            if ({1'b0, key} >= inode_limit) begin
               a.status = ST_RANGE;
            end else if (found >= 0) begin
               a.hit  = 1'b1;
               a.slot = found[SLOT_W-1:0];
            end else begin
               a.status = ST_ABSENT;
            end
         end
         OP_PUT: begin
            if (found >= 0) begin
               a.hit = 1'b1;
               pick  = found;
            end else begin
               for (i = 0; i < SLOTS; i++) begin
                  if (pick < 0 && !line_valid[i]) pick = i;
               end
               if (pick < 0) begin
                  // oldest stamp goes, first slot wins a tie
                  pick = 0;
                  for (i = 1; i < SLOTS; i++) begin
                     if (line_stamp[i] < line_stamp[pick]) pick = i;
                  end
                  a.evicted     = 1'b1;
                  a.evicted_key = line_key[pick];
               end
               line_valid[pick] = 1'b1;
               line_key[pick]   = key;
            end
            line_stamp[pick] = stamp_now;
            stamp_now        = stamp_now + 1'b1;
            a.slot           = pick[SLOT_W-1:0];
         end
         OP_REMOVE: begin
            if (found >= 0) begin
               line_valid[found] = 1'b0;
               a.hit  = 1'b1;
               a.slot = found[SLOT_W-1:0];
            end else begin
               a.status = ST_ABSENT;
            end
         end
         default: begin
         end
      endcase
      return a;
   endfunction

   always @(posedge clock) begin
      rsp_bus.ready <= ($urandom_range(99, 0) >= stall_pct);
   end

   always @(posedge clock) begin
      answer_type due;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (answers_due.size() == 0) begin
            $error("response word with no request outstanding");
            fault_count++;
         end else begin
            due = answers_due.pop_front();
            if (rsp_bus.status != due.status) begin
               $error("status expected %0d got %0d", due.status, rsp_bus.status);
               fault_count++;
            end
            if (rsp_bus.hit != due.hit) begin
               $error("hit expected %0d got %0d", due.hit, rsp_bus.hit);
               fault_count++;
            end
            if (rsp_bus.slot != due.slot) begin
               $error("slot expected %0d got %0d", due.slot, rsp_bus.slot);
               fault_count++;
            end
            if (rsp_bus.evicted != due.evicted) begin
               $error("evicted expected %0d got %0d", due.evicted, rsp_bus.evicted);
               fault_count++;
            end
            if (rsp_bus.evicted_key != due.evicted_key) begin
               $error("evicted_key expected %0d got %0d", due.evicted_key,
                      rsp_bus.evicted_key);
               fault_count++;
            end
         end
      end
   end

   task automatic send_word(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key);
      while ($urandom_range(99, 0) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.op    <= op;
      req_bus.key   <= key;
      do @(posedge clock); while (!req_bus.ready);
      answers_due.push_back(resolve_request(op, key));
   endtask

   // stop sending and wait for every outstanding response word
   task automatic settle();
      req_bus.valid <= 1'b0;
      do @(posedge clock); while (answers_due.size() != 0);
   endtask

   task automatic set_inode_limit(input logic [COUNT_W-1:0] limit);
      settle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= limit;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      inode_limit = limit;
   endtask

   task automatic test_empty_cache();
      set_inode_limit(COUNT_FULL);
      send_word(OP_LOOKUP, 16'h0000);
      send_word(OP_LOOKUP, 16'hFFFF);
      send_word(OP_REMOVE, 16'h0005);
      send_word(OP_UNDEFINED, 16'hFFFF);
   endtask

   task automatic test_fill_and_evict();
      int k;
      send_word(OP_PUT, 16'h0000);
      send_word(OP_PUT, 16'hFFFF);
      for (k = 0; k < SLOTS - 2; k++) send_word(OP_PUT, 16'(100 + k));
      // touch refreshes age, lookup does not
      send_word(OP_PUT, 16'h0000);
      send_word(OP_LOOKUP, 16'hFFFF);
      send_word(OP_PUT, 16'd200);
      send_word(OP_REMOVE, 16'd100);
      send_word(OP_PUT, 16'd300);
      send_word(OP_REMOVE, 16'd100);
   endtask

   task automatic test_range_limits();
      set_inode_limit('0);
      send_word(OP_LOOKUP, 16'h0000);
      send_word(OP_PUT, 16'd301);
      set_inode_limit(17'h0FFFF);
      send_word(OP_LOOKUP, 16'hFFFF);
      send_word(OP_LOOKUP, 16'hFFFE);
      set_inode_limit(COUNT_FULL);
      send_word(OP_LOOKUP, 16'd300);
      send_word(OP_LOOKUP, 16'hFFFF);
   endtask

   task automatic test_random_traffic(input int idle, input int stall, input int items,
                                      input bit narrow_limit);
      logic [KEY_W-1:0] pool_base;
      logic [OP_W-1:0]  op;
      logic [KEY_W-1:0] key;
      int r;
      int n;
      pool_base = 16'($urandom_range(65535 - 23, 0));
      if (narrow_limit) set_inode_limit({1'b0, pool_base} + 17'd12);
      else set_inode_limit(17'($urandom_range(65536, 0)));
      send_idle_pct = idle;
      stall_pct     = stall;
      for (n = 0; n < items; n++) begin
         r = $urandom_range(99, 0);
         if (r < 45) op = OP_PUT;
         else if (r < 75) op = OP_LOOKUP;
         else if (r < 95) op = OP_REMOVE;
         else op = OP_UNDEFINED;
         // a pool a bit larger than the cache gives hits and evictions
         if ($urandom_range(4, 0) != 0) key = pool_base + 16'($urandom_range(23, 0));
         else key = 16'($urandom);
         send_word(op, key);
      end
      send_idle_pct = 0;
      stall_pct     = 0;
   endtask

   initial begin
      int i;
      reset         = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.op    = OP_LOOKUP;
      req_bus.key   = '0;
      rsp_bus.ready = 1'b0;
      csr_wr_en     = 1'b0;
      csr_wr_data   = '0;
      for (i = 0; i < SLOTS; i++) begin
         line_valid[i] = 1'b0;
         line_key[i]   = '0;
         line_stamp[i] = '0;
      end
      stamp_now   = '0;
      inode_limit = INODE_COUNT_RESET;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      test_empty_cache();
      test_fill_and_evict();
      test_range_limits();
      test_random_traffic(0, 0, 120, 1'b1);
      test_random_traffic(67, 0, 120, 1'b0);
      test_random_traffic(0, 67, 120, 1'b1);
      test_random_traffic(38, 38, 120, 1'b0);

      settle();
      repeat (SLOTS + 4) @(posedge clock);
      if (fault_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
